// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define S2C_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define S2C_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/s2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_pkg
// Types, constants and helper functions of the spherical to Cartesian point
// converter.
// ----------------------------------------------------------------------------
package s2c_pkg;

   localparam int DIVIDEND_W = 49;
   localparam int DIVISOR_W  = 27;

   localparam logic [17:0] MIN_RADIUS_RST    = 18'd55760;
   localparam logic [17:0] MAX_RADIUS_RST    = 18'd101936;
   localparam logic [13:0] SHIFT_DIVISOR_RST = 14'd16000;
   localparam logic [12:0] RADIAL_SIZE_RST   = 13'd256;

   localparam logic signed [19:0] DEG90_Q8  = 20'sd23040;
   localparam logic signed [19:0] DEG180_Q8 = 20'sd46080;
   localparam logic signed [19:0] DEG360_Q8 = 20'sd92160;

   // Radians per 1/256 degree, scaled by 2^46.
   localparam logic [32:0] RAD_PER_Q8DEG = 33'd4797524517;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

   typedef enum logic [1:0] {
      CSR_MIN_RADIUS    = 2'd0,
      CSR_MAX_RADIUS    = 2'd1,
      CSR_SHIFT_DIVISOR = 2'd2,
      CSR_RADIAL_SIZE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic rneg;
      logic fault;
   } div_tag_type;

   typedef struct packed {
      logic [14:0] mag;
      logic        neg_angle;
      logic        flip;
   } angle_type;

   // Three Q30 factors: cos(phi)sin(theta), sin(phi)sin(theta), cos(theta).
   typedef logic [2:0][32:0] trig_type;

   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] v;
      case (idx)
         5'd0:  v = 31'h3243F6A8;
         5'd1:  v = 31'h1DAC6705;
         5'd2:  v = 31'h0FADBAFC;
         5'd3:  v = 31'h07F56EA6;
         5'd4:  v = 31'h03FEAB76;
         5'd5:  v = 31'h01FFD55B;
         5'd6:  v = 31'h00FFFAAA;
         5'd7:  v = 31'h007FFF55;
         5'd8:  v = 31'h003FFFEA;
         5'd9:  v = 31'h001FFFFD;
         5'd10: v = 31'h000FFFFF;
         5'd11: v = 31'h0007FFFF;
         5'd12: v = 31'h0003FFFF;
         5'd13: v = 31'h0001FFFF;
         5'd14: v = 31'h0000FFFF;
         5'd15: v = 31'h00007FFF;
         5'd16: v = 31'h00003FFF;
         5'd17: v = 31'h00001FFF;
         5'd18: v = 31'h00000FFF;
         5'd19: v = 31'h000007FF;
         5'd20: v = 31'h000003FF;
         5'd21: v = 31'h000001FF;
         5'd22: v = 31'h000000FF;
         5'd23: v = 31'h0000007F;
         5'd24: v = 31'h0000003F;
         5'd25: v = 31'h0000001F;
         5'd26: v = 31'h0000000F;
         5'd27: v = 31'h00000008;
         5'd28: v = 31'h00000004;
         5'd29: v = 31'h00000002;
         5'd30: v = 31'h00000001;
         default: v = 31'h00000000;
      endcase
      return v;
   endfunction

   // Reduces an angle in 1/256 degree to [-90, 90] degrees. A fold by half a
   // turn sets flip, which later negates both sine and cosine.
   function automatic angle_type fold_angle(input logic signed [18:0] ang);
      logic signed [19:0] w;
      angle_type r;
      w = {ang[18], ang};
      if (w < 0) begin
         w = w + DEG360_Q8;
         if (w < 0) begin
            w = w + DEG360_Q8;
         end
      end else if (w >= DEG360_Q8) begin
         w = w - DEG360_Q8;
      end
      if (w >= DEG180_Q8) begin
         w = w - DEG360_Q8;
      end
      r.flip = 1'b0;
      if (w > DEG90_Q8) begin
         w = w - DEG180_Q8;
         r.flip = 1'b1;
      end else if (w < -DEG90_Q8) begin
         w = w + DEG180_Q8;
         r.flip = 1'b1;
      end
      r.neg_angle = w[19];
      r.mag = r.neg_angle ? 15'(-w) : w[14:0];
      return r;
   endfunction

endpackage

// ===== rtl/s2c_divider.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// s2c_divider
// Pipelined restoring divider: one quotient bit per stage, a side tag and a
// valid bit travel with each operand pair.
// ----------------------------------------------------------------------------
module s2c_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_vld,
   input  logic [s2c_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [s2c_pkg::DIVISOR_W-1:0]       divisor,
   input  s2c_pkg::div_tag_type                in_tag,
   output logic                                out_vld,
   output logic [s2c_pkg::DIVIDEND_W-1:0]      quotient,
   output s2c_pkg::div_tag_type                out_tag
);

   localparam int NW = s2c_pkg::DIVIDEND_W;
   localparam int DW = s2c_pkg::DIVISOR_W;

   logic                 vld_ff [NW];
   logic [DW-1:0]        rem_ff [NW];
   logic [NW-1:0]        nq_ff  [NW];
   logic [DW-1:0]        den_ff [NW];
   s2c_pkg::div_tag_type tag_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic                 vld_prev;
      logic [DW-1:0]        rem_prev;
      logic [NW-1:0]        nq_prev;
      logic [DW-1:0]        den_prev;
      s2c_pkg::div_tag_type tag_prev;
      logic [DW:0]          trial;
      logic [DW:0]          diff;
      logic                 ge;
      logic [DW-1:0]        rem_in;
      logic [NW-1:0]        nq_in;

      if (i == 0) begin : g_first
         assign vld_prev = in_vld;
         assign rem_prev = '0;
         assign nq_prev  = dividend;
         assign den_prev = divisor;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign nq_prev  = nq_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      // The dividend shifts out at the top while quotient bits enter below.
      assign trial  = {rem_prev, nq_prev[NW-1]};
      assign diff   = trial - {1'b0, den_prev};
      assign ge     = trial >= {1'b0, den_prev};
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      assign nq_in  = {nq_prev[NW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            nq_ff[i]  <= nq_in;
            den_ff[i] <= den_prev;
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign out_vld  = vld_ff[NW-1];
   assign quotient = nq_ff[NW-1];
   assign out_tag  = tag_ff[NW-1];

   `S2C_ASSERT_IMPLIES(a_rem_below_den, clock, reset,
      vld_ff[NW-1] && den_ff[NW-1] != '0, rem_ff[NW-1] < den_ff[NW-1],
      "divider remainder not below divisor")
   `S2C_ASSERT_NEXT(a_hold_on_stall, clock, reset, !en,
      $stable(vld_ff[NW-1]) && $stable(nq_ff[NW-1]),
      "divider output moved while stalled")

endmodule

// ===== rtl/s2c_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage, followed by
// an output stage that applies the half-turn fold.
// ----------------------------------------------------------------------------
module s2c_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] angle,
   input  logic               flip,
   output logic signed [31:0] cos_q30,
   output logic signed [31:0] sin_q30
);

   logic signed [31:0] x_ff    [STAGES];
   logic signed [31:0] y_ff    [STAGES];
   logic signed [32:0] z_ff    [STAGES];
   logic               flip_ff [STAGES];
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [31:0] x_prev;
      logic signed [31:0] y_prev;
      logic signed [32:0] z_prev;
      logic               flip_prev;
      logic signed [32:0] step;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [32:0] z_in;

      if (i == 0) begin : g_first
         assign x_prev    = s2c_pkg::CORDIC_GAIN_Q30;
         assign y_prev    = '0;
         assign z_prev    = angle;
         assign flip_prev = flip;
      end else begin : g_next
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign flip_prev = flip_ff[i-1];
      end

      assign step = $signed({2'b00, s2c_pkg::atan_q30(5'(i))});

      always_comb begin
         if (z_prev[32]) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + step;
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - step;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            flip_ff[i] <= flip_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];
         sin_ff <= flip_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

// ===== rtl/spherical_to_cartesian_point.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// spherical_to_cartesian_point
// Converts one point in spherical voxel coordinates to a Cartesian point.
// ----------------------------------------------------------------------------
// A request beat carries longitude, radial position and colatitude; the
// response beat carries x, y, z in 1/65536 unit and a fault flag. Both
// channels use valid/ready. The csr_ write port sets the radius mapping, the
// shift divisor and the radial grid size; write it only while no point is in
// flight.
// A point passes 54 register stages: three setup stages, the 49-stage radius
// divider, one multiply stage and the output register. The two CORDIC units
// run beside the divider and are delayed to match it. A new point is taken
// every cycle unless the pipeline holds for a stalled receiver.
// The pipeline advances as a whole whenever the output register is empty or
// being read; when the receiver stalls with a beat waiting, every stage holds
// and req_ready drops. Reset empties the pipeline and loads the register
// defaults; it takes effect at the next clock edge.
// A zero divisor or grid size returns zero coordinates with fault set.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_point #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [17:0] req_longitude,
   input  logic [20:0]        req_radial_position,
   input  logic signed [17:0] req_colatitude,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [32:0] rsp_x_coord,
   output logic signed [32:0] rsp_y_coord,
   output logic signed [32:0] rsp_z_coord,
   output logic               rsp_fault,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [17:0]        csr_data
);

   localparam int NW         = s2c_pkg::DIVIDEND_W;
   localparam int DW         = s2c_pkg::DIVISOR_W;
   localparam int TRIG_DELAY = NW - CORDIC_STAGES - 2;

   function automatic logic signed [32:0] rad_to_z(input logic [47:0] prod,
                                                   input logic neg);
      logic [47:0] t;
      logic signed [32:0] z;
      t = prod + 48'd32768;
      z = $signed({1'b0, t[47:16]});
      return neg ? -z : z;
   endfunction

   function automatic logic [32:0] mul_q30(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      p = p + 64'sd536870912;
      return p[62:30];
   endfunction

   // Rounds |r|*|p| / 2^30 half away from zero, applies the sign, saturates.
   function automatic logic [32:0] finish_coord(input logic [56:0] hi,
                                                input logic [55:0] lo,
                                                input logic neg);
      logic [56:0] inner;
      logic [51:0] q;
      logic [51:0] nq;
      logic [32:0] v;
      inner = {27'd0, hi[5:0], 24'd0} + {1'b0, lo} + 57'd536870912;
      q = {1'b0, hi[56:6]} + {25'd0, inner[56:30]};
      nq = -q;
      if (neg) begin
         v = (q > 52'h1_0000_0000) ? 33'h1_0000_0000 : nq[32:0];
      end else begin
         v = (q > 52'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : q[32:0];
      end
      return v;
   endfunction

   // Configuration registers.
   logic [17:0] min_radius_ff;
   logic [17:0] max_radius_ff;
   logic [13:0] shift_divisor_ff;
   logic [12:0] radial_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_ff    <= s2c_pkg::MIN_RADIUS_RST;
         max_radius_ff    <= s2c_pkg::MAX_RADIUS_RST;
         shift_divisor_ff <= s2c_pkg::SHIFT_DIVISOR_RST;
         radial_size_ff   <= s2c_pkg::RADIAL_SIZE_RST;
      end else if (csr_we) begin
         case (s2c_pkg::csr_index_type'(csr_index))
            s2c_pkg::CSR_MIN_RADIUS:    min_radius_ff    <= csr_data;
            s2c_pkg::CSR_MAX_RADIUS:    max_radius_ff    <= csr_data;
            s2c_pkg::CSR_SHIFT_DIVISOR: shift_divisor_ff <= csr_data[13:0];
            s2c_pkg::CSR_RADIAL_SIZE:   radial_size_ff   <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   logic pipe_en;
   logic rsp_vld_ff;

   assign pipe_en   = !rsp_vld_ff || rsp_ready;
   assign req_ready = pipe_en;

   // Stage 1: products of the radius mapping, angle reduction.
   logic signed [18:0]  diff_s;
   logic signed [21:0]  pos_s;
   logic [30:0]         p1_in;
   logic signed [40:0]  p2_in;
   logic [DW-1:0]       den1_in;
   s2c_pkg::angle_type  phi1_in;
   s2c_pkg::angle_type  th1_in;

   logic                s1_vld_ff;
   logic [30:0]         p1_ff;
   logic signed [40:0]  p2_ff;
   logic [DW-1:0]       den1_ff;
   logic                fault1_ff;
   s2c_pkg::angle_type  phi1_ff;
   s2c_pkg::angle_type  th1_ff;

   assign diff_s  = $signed({1'b0, max_radius_ff}) - $signed({1'b0, min_radius_ff});
   assign pos_s   = $signed({1'b0, req_radial_position});
   assign p1_in   = min_radius_ff * radial_size_ff;
   assign p2_in   = pos_s * diff_s;
   assign den1_in = shift_divisor_ff * radial_size_ff;
   assign phi1_in = s2c_pkg::fold_angle($signed({req_longitude[17], req_longitude})
                                        + 19'sd46080);
   assign th1_in  = s2c_pkg::fold_angle({req_colatitude[17], req_colatitude});

   // Stage 2: radius numerator, angle scaling to radians.
   logic signed [41:0]  num2_in;
   logic [47:0]         rphi2_in;
   logic [47:0]         rth2_in;

   logic                s2_vld_ff;
   logic signed [41:0]  num2_ff;
   logic [DW-1:0]       den2_ff;
   logic                fault2_ff;
   logic [47:0]         rphi2_ff;
   logic [47:0]         rth2_ff;
   logic                phi_neg2_ff;
   logic                th_neg2_ff;
   logic                phi_flip2_ff;
   logic                th_flip2_ff;

   assign num2_in  = $signed({3'b000, p1_ff, 8'h00}) + $signed({p2_ff[40], p2_ff});
   assign rphi2_in = phi1_ff.mag * s2c_pkg::RAD_PER_Q8DEG;
   assign rth2_in  = th1_ff.mag * s2c_pkg::RAD_PER_Q8DEG;

   // Stage 3: rounded dividend, signed CORDIC angles.
   logic [40:0]          nmag3;
   logic [NW-1:0]        dividend3_in;
   s2c_pkg::div_tag_type tag3_in;

   logic                 s3_vld_ff;
   logic [NW-1:0]        dividend3_ff;
   logic [DW-1:0]        den3_ff;
   s2c_pkg::div_tag_type tag3_ff;
   logic signed [32:0]   zphi3_ff;
   logic signed [32:0]   zth3_ff;
   logic                 phi_flip3_ff;
   logic                 th_flip3_ff;

   assign nmag3        = num2_ff[41] ? 41'(-num2_ff) : num2_ff[40:0];
   assign dividend3_in = {nmag3, 8'h00} + NW'(den2_ff >> 1);
   assign tag3_in.rneg  = num2_ff[41];
   assign tag3_in.fault = fault2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         den1_ff      <= den1_in;
         fault1_ff    <= shift_divisor_ff == '0 || radial_size_ff == '0;
         phi1_ff      <= phi1_in;
         th1_ff       <= th1_in;

         num2_ff      <= num2_in;
         den2_ff      <= den1_ff;
         fault2_ff    <= fault1_ff;
         rphi2_ff     <= rphi2_in;
         rth2_ff      <= rth2_in;
         phi_neg2_ff  <= phi1_ff.neg_angle;
         th_neg2_ff   <= th1_ff.neg_angle;
         phi_flip2_ff <= phi1_ff.flip;
         th_flip2_ff  <= th1_ff.flip;

         dividend3_ff <= dividend3_in;
         den3_ff      <= den2_ff;
         tag3_ff      <= tag3_in;
         zphi3_ff     <= rad_to_z(rphi2_ff, phi_neg2_ff);
         zth3_ff      <= rad_to_z(rth2_ff, th_neg2_ff);
         phi_flip3_ff <= phi_flip2_ff;
         th_flip3_ff  <= th_flip2_ff;
      end
   end

   // Radius division and trigonometry run side by side.
   logic                 div_vld;
   logic [NW-1:0]        rmag;
   s2c_pkg::div_tag_type div_tag;
   logic signed [31:0]   cos_phi;
   logic signed [31:0]   sin_phi;
   logic signed [31:0]   cos_th;
   logic signed [31:0]   sin_th;

   s2c_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (s3_vld_ff),
      .dividend (dividend3_ff),
      .divisor  (den3_ff),
      .in_tag   (tag3_ff),
      .out_vld  (div_vld),
      .quotient (rmag),
      .out_tag  (div_tag)
   );

   s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
      .clock   (clock),
      .en      (pipe_en),
      .angle   (zphi3_ff),
      .flip    (phi_flip3_ff),
      .cos_q30 (cos_phi),
      .sin_q30 (sin_phi)
   );

   s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
      .clock   (clock),
      .en      (pipe_en),
      .angle   (zth3_ff),
      .flip    (th_flip3_ff),
      .cos_q30 (cos_th),
      .sin_q30 (sin_th)
   );

   s2c_pkg::trig_type trig_mul_ff;
   s2c_pkg::trig_type trig_dly_ff [TRIG_DELAY];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         trig_mul_ff[0] <= mul_q30(cos_phi, sin_th);
         trig_mul_ff[1] <= mul_q30(sin_phi, sin_th);
         trig_mul_ff[2] <= {cos_th[31], cos_th};
         trig_dly_ff[0] <= trig_mul_ff;
         for (int k = 1; k < TRIG_DELAY; k++) begin
            trig_dly_ff[k] <= trig_dly_ff[k-1];
         end
      end
   end

   // Scale stage: the radius is split so each product stays narrow.
   s2c_pkg::trig_type trig_al;
   logic [56:0]       hi_in  [3];
   logic [55:0]       lo_in  [3];
   logic              neg_in [3];

   logic              s53_vld_ff;
   logic              fault53_ff;
   logic [56:0]       hi_ff  [3];
   logic [55:0]       lo_ff  [3];
   logic              neg_ff [3];

   assign trig_al = trig_dly_ff[TRIG_DELAY-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [32:0] pneg_v;
         logic [31:0] pm;
         pneg_v = -trig_al[k];
         pm = trig_al[k][32] ? pneg_v[31:0] : trig_al[k][31:0];
         hi_in[k]  = rmag[NW-1:24] * pm;
         lo_in[k]  = rmag[23:0] * pm;
         neg_in[k] = div_tag.rneg ^ trig_al[k][32];
      end
   end

   logic [32:0] x_ff;
   logic [32:0] y_ff;
   logic [32:0] z_ff;
   logic        fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s53_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s53_vld_ff <= div_vld;
         rsp_vld_ff <= s53_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fault53_ff <= div_tag.fault;
         for (int k = 0; k < 3; k++) begin
            hi_ff[k]  <= hi_in[k];
            lo_ff[k]  <= lo_in[k];
            neg_ff[k] <= neg_in[k];
         end
         fault_ff <= fault53_ff;
         x_ff <= fault53_ff ? '0 : finish_coord(hi_ff[0], lo_ff[0], neg_ff[0]);
         y_ff <= fault53_ff ? '0 : finish_coord(hi_ff[1], lo_ff[1], neg_ff[1]);
         z_ff <= fault53_ff ? '0 : finish_coord(hi_ff[2], lo_ff[2], neg_ff[2]);
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_x_coord = $signed(x_ff);
   assign rsp_y_coord = $signed(y_ff);
   assign rsp_z_coord = $signed(z_ff);
   assign rsp_fault   = fault_ff;

   `S2C_ASSERT_IMPLIES(a_fault_zero, clock, reset, rsp_valid && rsp_fault,
      rsp_x_coord == '0 && rsp_y_coord == '0 && rsp_z_coord == '0,
      "fault beat with nonzero coordinates")
   `S2C_ASSERT_IMPLIES(a_ready_low_only_full, clock, reset, !req_ready,
      rsp_valid && !rsp_ready, "request side stalled without a waiting beat")
   `S2C_ASSERT_NEXT(a_stall_freeze, clock, reset, !pipe_en,
      $stable(s3_vld_ff) && $stable(s53_vld_ff), "pipeline moved while stalled")
   `S2C_ASSERT_NEXT(a_out_follows, clock, reset, pipe_en && s53_vld_ff,
      rsp_valid, "scaled point did not reach the output register")

endmodule
